>>> sv/smf_pkg.sv
// shared constants, types and state codes for the midi file event serializer
`timescale 1ns / 1ps

package smf_pkg;

  localparam int VLQ_MAX_BYTES_DEF = 4;

  // op codes of an input word
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_TEMPO   = 2'd2;

  // fixed bytes of the stream
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] META_PREFIX = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] TEMPO_LEN   = 8'h03;
  localparam logic [7:0] VLQ_MORE    = 8'h80;
  localparam logic [7:0] VLQ_MASK    = 8'h7F;

  // tempo divider
  localparam int DIV_QW = 26;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = $clog2(DIV_QW);
  localparam logic [DIV_QW-1:0] USEC_PER_MINUTE = 26'd60000000;
  localparam logic [23:0] TEMPO_MAX = 24'hFFFFFF;

  // tempo meta bytes after the delta
  localparam int TEMPO_BYTES = 6;
  localparam int TCW = $clog2(TEMPO_BYTES);

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_VLQ   = 5'b00100,
    S_BYTE  = 5'b01000,
    S_TEMPO = 5'b10000
  } state_t;

endpackage

>>> sv/smf_evt_if.sv
// input channel: timed midi message words
`timescale 1ns / 1ps

interface smf_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] song_tick;
  logic [7:0]  data_byte;
  logic [28:0] msg_length;
  logic [15:0] tempo_bpm;

  modport source (output valid, op, song_tick, data_byte, msg_length, tempo_bpm,
                  input ready);
  modport sink (input valid, op, song_tick, data_byte, msg_length, tempo_bpm,
                output ready);
endinterface

>>> sv/smf_trk_if.sv
// output channel: track data bytes
`timescale 1ns / 1ps

interface smf_trk_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

>>> sv/smf_div.sv
// iterative restoring divider for 60000000 / bpm, one quotient bit per cycle
`timescale 1ns / 1ps

module smf_div (
  input  logic              clk,
  input  logic              rst,
  input  smf_pkg::div_req_t req,
  output smf_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [smf_pkg::DIV_CW-1:0]     cnt;
  logic [smf_pkg::DIV_DW-1:0]     rem;
  logic [smf_pkg::DIV_DW-1:0]     dvs;
  logic [smf_pkg::DIV_QW-1:0]     dq;
  logic [smf_pkg::DIV_DW:0]       trial;
  logic [smf_pkg::DIV_DW:0]       diff;
  logic                           ge;

  // dividend bits shift out of the top of dq while quotient bits enter below
  assign trial = {rem, dq[smf_pkg::DIV_QW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= smf_pkg::DIV_CW'(smf_pkg::DIV_QW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      dq  <= smf_pkg::USEC_PER_MINUTE;
    end else if (busy) begin
      rem <= ge ? diff[smf_pkg::DIV_DW-1:0] : trial[smf_pkg::DIV_DW-1:0];
      dq  <= {dq[smf_pkg::DIV_QW-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

>>> sv/midi_file_event_serializer.sv
// midi file event serializer: turns timed midi words into track data bytes
// a message start emits the delta bytes, the status byte and, for sysex, the length bytes; payload emits one byte
// a tempo event waits for the 26-step divider, then emits the delta bytes and six meta bytes
// one input word at a time; output bytes leave at one per cycle when not stalled
// synchronous reset clears the sequencer, the output valid and the previous tick
`timescale 1ns / 1ps

module midi_file_event_serializer #(
  parameter int VLQ_MAX_BYTES = smf_pkg::VLQ_MAX_BYTES_DEF
) (
  input logic clk,
  input logic rst,
  smf_evt_if.sink   evt,
  smf_trk_if.source trk
);

  localparam int VW = 7 * VLQ_MAX_BYTES;
  localparam int IW = $clog2(VLQ_MAX_BYTES);

  smf_pkg::state_t   state;
  smf_pkg::div_req_t div_req;
  smf_pkg::div_rsp_t div_rsp;

  logic [1:0]                 op;
  logic [7:0]                 first_byte;
  logic [28:0]                len_m1;
  logic [31:0]                prev_tick;
  logic [VW-1:0]              vlq_val;
  logic [IW-1:0]              vlq_idx;
  logic                       vlq_len;
  logic [smf_pkg::TCW-1:0]    tcnt;
  logic [23:0]                tempo;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  logic          accept;
  logic          can_load;
  logic [31:0]   vlq_src;
  logic [VW-1:0] vlq_sat;
  logic [IW-1:0] vlq_top;
  logic [6:0]    vlq_grp;
  logic [7:0]    vlq_byte;
  logic [7:0]    tempo_byte;

  function automatic logic [VW-1:0] sat_vlq(input logic [31:0] x);
    logic [VW+31:0] w;
    w = {{VW{1'b0}}, x};
    if (w[VW+31:VW] != '0) return '1;
    return w[VW-1:0];
  endfunction

  function automatic logic [IW-1:0] top_group(input logic [VW-1:0] v);
    logic [IW-1:0] t;
    t = '0;
    for (int g = 1; g < VLQ_MAX_BYTES; g++) begin
      if ((v >> (7 * g)) != '0) t = IW'(g);
    end
    return t;
  endfunction

  assign accept   = evt.valid && evt.ready;
  assign evt.ready = (state == smf_pkg::S_IDLE);
  assign can_load = !out_valid || trk.ready;

  // delta on accept, sysex length less one after the first byte
  assign vlq_src = (state == smf_pkg::S_IDLE) ? (evt.song_tick - prev_tick)
                                              : {3'b000, len_m1};
  assign vlq_sat = sat_vlq(vlq_src);
  assign vlq_top = top_group(vlq_sat);

  always_comb begin
    vlq_grp = '0;
    for (int g = 0; g < VLQ_MAX_BYTES; g++) begin
      if (vlq_idx == IW'(g)) vlq_grp = vlq_val[7*g +: 7];
    end
  end

  assign vlq_byte = (vlq_idx != '0) ? (smf_pkg::VLQ_MORE | {1'b0, vlq_grp})
                                    : (smf_pkg::VLQ_MASK & {1'b0, vlq_grp});

  always_comb begin
    case (tcnt)
      3'd0:    tempo_byte = smf_pkg::META_PREFIX;
      3'd1:    tempo_byte = smf_pkg::META_TEMPO;
      3'd2:    tempo_byte = smf_pkg::TEMPO_LEN;
      3'd3:    tempo_byte = tempo[23:16];
      3'd4:    tempo_byte = tempo[15:8];
      default: tempo_byte = tempo[7:0];
    endcase
  end

  assign div_req.start   = accept && (evt.op == smf_pkg::OP_TEMPO);
  assign div_req.divisor = evt.tempo_bpm;

  smf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smf_pkg::S_IDLE;
      prev_tick <= '0;
      out_valid <= 1'b0;
    end else begin
      if (trk.ready) out_valid <= 1'b0;
      unique case (state)
        smf_pkg::S_IDLE: begin
          if (accept) begin
            case (evt.op)
              smf_pkg::OP_START: begin
                prev_tick <= evt.song_tick;
                state     <= smf_pkg::S_VLQ;
              end
              smf_pkg::OP_PAYLOAD: state <= smf_pkg::S_BYTE;
              smf_pkg::OP_TEMPO: begin
                prev_tick <= evt.song_tick;
                state     <= smf_pkg::S_DIV;
              end
              default: state <= smf_pkg::S_IDLE;
            endcase
          end
        end
        smf_pkg::S_DIV: begin
          if (div_rsp.done) state <= smf_pkg::S_VLQ;
        end
        smf_pkg::S_VLQ: begin
          if (can_load) begin
            out_valid <= 1'b1;
            if (vlq_idx == '0) begin
              if (vlq_len) state <= smf_pkg::S_IDLE;
              else if (op == smf_pkg::OP_TEMPO) state <= smf_pkg::S_TEMPO;
              else state <= smf_pkg::S_BYTE;
            end
          end
        end
        smf_pkg::S_BYTE: begin
          if (can_load) begin
            out_valid <= 1'b1;
            if (op == smf_pkg::OP_START && first_byte == smf_pkg::SYSEX_START) begin
              state <= smf_pkg::S_VLQ;
            end else begin
              state <= smf_pkg::S_IDLE;
            end
          end
        end
        smf_pkg::S_TEMPO: begin
          if (can_load) begin
            out_valid <= 1'b1;
            if (tcnt == smf_pkg::TCW'(smf_pkg::TEMPO_BYTES - 1)) state <= smf_pkg::S_IDLE;
          end
        end
        default: state <= smf_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      smf_pkg::S_IDLE: begin
        if (accept) begin
          op         <= evt.op;
          first_byte <= evt.data_byte;
          len_m1     <= (evt.msg_length == '0) ? '0 : evt.msg_length - 1'b1;
          vlq_val    <= vlq_sat;
          vlq_idx    <= vlq_top;
          vlq_len    <= 1'b0;
          tcnt       <= '0;
        end
      end
      smf_pkg::S_DIV: begin
        if (div_rsp.done) begin
          tempo <= (div_rsp.quotient[smf_pkg::DIV_QW-1:24] != '0)
                   ? smf_pkg::TEMPO_MAX : div_rsp.quotient[23:0];
        end
      end
      smf_pkg::S_VLQ: begin
        if (can_load) begin
          out_byte <= vlq_byte;
          out_last <= (vlq_idx == '0) && vlq_len;
          if (vlq_idx != '0) vlq_idx <= vlq_idx - 1'b1;
        end
      end
      smf_pkg::S_BYTE: begin
        if (can_load) begin
          out_byte <= first_byte;
          out_last <= !(op == smf_pkg::OP_START && first_byte == smf_pkg::SYSEX_START);
          vlq_val  <= vlq_sat;
          vlq_idx  <= vlq_top;
          vlq_len  <= 1'b1;
        end
      end
      smf_pkg::S_TEMPO: begin
        if (can_load) begin
          out_byte <= tempo_byte;
          out_last <= (tcnt == smf_pkg::TCW'(smf_pkg::TEMPO_BYTES - 1));
          tcnt     <= tcnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign trk.valid       = out_valid;
  assign trk.out_byte    = out_byte;
  assign trk.last_of_run = out_last;

endmodule

>>> verif/midi_file_event_serializer_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the midi file event serializer: random and directed events

module midi_file_event_serializer_test;

  localparam int VLQ_GROUPS = smf_pkg::VLQ_MAX_BYTES_DEF;
  localparam logic [31:0] VLQ_CAP = (32'd1 << (7 * VLQ_GROUPS)) - 32'd1;
  localparam logic [31:0] TEMPO_CEIL = {8'h00, smf_pkg::TEMPO_MAX};
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [7:0] SYSEX_END = 8'hF7;
  localparam int RANDOM_EVENTS = 80;
  localparam int PHASES = 4;
  localparam int SETTLE_CYCLES = 64;
  // the limit spans the quiet tempo divide and long stall and gap runs
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] song_tick;
    logic [7:0]  data_byte;
    logic [28:0] msg_length;
    logic [15:0] tempo_bpm;
  } smf_event_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } track_byte_t;

  class track_scoreboard;
    logic [31:0] previous_tick;
    track_byte_t bytes_due[$];
    int          errors;

    function new();
      previous_tick = '0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    function int pending();
      return bytes_due.size();
    endfunction

    function void push_byte(logic [7:0] value);
      track_byte_t entry;
      entry.value = value;
      entry.last = 1'b0;
      bytes_due.push_back(entry);
    endfunction

    // 7 bits per byte, high group first, continuation bit on all but the last
    function void push_vlq(logic [31:0] v);
      logic [31:0] capped;
      logic [7:0]  b;
      int          groups;
      capped = (v > VLQ_CAP) ? VLQ_CAP : v;
      groups = 1;
      while (groups < VLQ_GROUPS && (capped >> (7 * groups)) != 0) groups++;
      for (int g = groups - 1; g >= 0; g--) begin
        b = 8'(capped >> (7 * g)) & smf_pkg::VLQ_MASK;
        if (g != 0) b = b | smf_pkg::VLQ_MORE;
        push_byte(b);
      end
    endfunction

    function void push_delta(logic [31:0] tick);
      push_vlq(tick - previous_tick);
      previous_tick = tick;
    endfunction

    function void note_event(smf_event_t e);
      logic [31:0] usec;
      track_byte_t entry;
      case (e.op)
        smf_pkg::OP_START: begin
          push_delta(e.song_tick);
          push_byte(e.data_byte);
          if (e.data_byte == smf_pkg::SYSEX_START)
            push_vlq(e.msg_length == 0 ? 32'd0 : {3'b000, e.msg_length} - 32'd1);
        end
        smf_pkg::OP_PAYLOAD: begin
          push_byte(e.data_byte);
        end
        smf_pkg::OP_TEMPO: begin
          if (e.tempo_bpm == 0) usec = TEMPO_CEIL;
          else usec = 32'(smf_pkg::USEC_PER_MINUTE) / 32'(e.tempo_bpm);
          if (usec > TEMPO_CEIL) usec = TEMPO_CEIL;
          push_delta(e.song_tick);
          push_byte(smf_pkg::META_PREFIX);
          push_byte(smf_pkg::META_TEMPO);
          push_byte(smf_pkg::TEMPO_LEN);
          push_byte(usec[23:16]);
          push_byte(usec[15:8]);
          push_byte(usec[7:0]);
        end
        default: begin
          return;
        end
      endcase
      entry = bytes_due.pop_back();
      entry.last = 1'b1;
      bytes_due.push_back(entry);
    endfunction

    task check_byte(logic [7:0] value, logic last);
      track_byte_t due;
      if (bytes_due.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", value, last));
        return;
      end
      due = bytes_due.pop_front();
      if (value !== due.value)
        report($sformatf("out_byte %02h, want %02h", value, due.value));
      if (last !== due.last)
        report($sformatf("last_of_run %0b, want %0b (byte %02h)", last, due.last, due.value));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  smf_evt_if evt();
  smf_trk_if trk();

  track_scoreboard trk_sb = new();

  int          send_idle_pct;
  int          recv_stall_pct;
  int          next_gap;
  int          events_sent;
  int          stall_cycles;
  logic [31:0] cur_tick;

  midi_file_event_serializer dut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .trk (trk)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    trk.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // accepted input words feed the predictor before any output is checked
  always @(posedge clk) begin : monitor
    smf_event_t ev;
    logic       moved;
    if (!rst) begin
      moved = 1'b0;
      if (evt.valid && evt.ready) begin
        ev.op = evt.op;
        ev.song_tick = evt.song_tick;
        ev.data_byte = evt.data_byte;
        ev.msg_length = evt.msg_length;
        ev.tempo_bpm = evt.tempo_bpm;
        trk_sb.note_event(ev);
        moved = 1'b1;
      end
      if (trk.valid && trk.ready) begin
        trk_sb.check_byte(trk.out_byte, trk.last_of_run);
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // called at a falling edge; leaves valid high only when the next word follows at once
  task send_event(smf_event_t e);
    repeat (next_gap) @(negedge clk);
    evt.valid <= 1'b1;
    evt.op <= e.op;
    evt.song_tick <= e.song_tick;
    evt.data_byte <= e.data_byte;
    evt.msg_length <= e.msg_length;
    evt.tempo_bpm <= e.tempo_bpm;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    if (e.op != OP_UNUSED) events_sent++;
    @(negedge clk);
    next_gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && next_gap < 200) next_gap++;
    if (next_gap > 0) evt.valid <= 1'b0;
  endtask

  task send_fields(logic [1:0] op, logic [31:0] tick, logic [7:0] data,
                   logic [28:0] len, logic [15:0] bpm);
    smf_event_t e;
    e.op = op;
    e.song_tick = tick;
    e.data_byte = data;
    e.msg_length = len;
    e.tempo_bpm = bpm;
    send_event(e);
  endtask

  // sender holds off until every expected byte has come out
  task drain_track();
    if (next_gap == 0) begin
      evt.valid <= 1'b0;
      next_gap = 1;
    end
    while (trk_sb.pending() != 0) @(negedge clk);
  endtask

  function logic [31:0] next_tick();
    int          r;
    logic [31:0] step;
    r = $urandom_range(0, 99);
    if (r < 50) step = $urandom_range(0, 127);
    else if (r < 75) step = $urandom_range(128, 16383);
    else if (r < 88) step = $urandom_range(16384, 32'h00FF_FFFF);
    else if (r < 94) step = $urandom;
    else step = 32'd0;
    cur_tick = cur_tick + step;
    return cur_tick;
  endfunction

  initial begin
    smf_event_t  ev;
    int          kind;
    int          extra;
    int          random_start;
    int          phase_goal;
    logic [7:0]  status;

    rst = 1'b1;
    evt.valid = 1'b0;
    evt.op = smf_pkg::OP_START;
    evt.song_tick = '0;
    evt.data_byte = '0;
    evt.msg_length = '0;
    evt.tempo_bpm = '0;
    trk.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    next_gap = 0;
    events_sent = 0;
    stall_cycles = 0;
    cur_tick = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // delta boundaries of one to four vlq bytes, saturation and tick wrap
    send_fields(smf_pkg::OP_START, 32'd0, 8'h90, 29'd3, 16'hFFFF);
    send_fields(smf_pkg::OP_PAYLOAD, 32'hFFFF_FFFF, 8'h00, 29'h1FFF_FFFF, 16'h0000);
    send_fields(smf_pkg::OP_PAYLOAD, 32'd0, 8'hFF, 29'd0, 16'd120);
    send_fields(smf_pkg::OP_START, 32'd127, 8'h80, 29'd3, 16'd1);
    send_fields(smf_pkg::OP_START, 32'd255, 8'hC0, 29'd2, 16'd2);
    send_fields(smf_pkg::OP_START, 32'd16639, 8'h00, 29'd1, 16'd3);
    send_fields(smf_pkg::OP_START, 32'd2113791, 8'hFF, 29'd1, 16'd4);
    send_fields(smf_pkg::OP_START, 32'd270549246, 8'hB0, 29'd3, 16'd5);
    send_fields(smf_pkg::OP_START, 32'd538984702, 8'hE0, 29'd3, 16'd6);
    send_fields(smf_pkg::OP_START, 32'hFFFF_FFFF, 8'hA0, 29'd3, 16'd7);
    send_fields(smf_pkg::OP_START, 32'd5, 8'hD0, 29'd2, 16'd8);
    // sysex length prefix: empty, one byte, largest fitting, saturating
    send_fields(smf_pkg::OP_START, 32'd5, smf_pkg::SYSEX_START, 29'd0, 16'd9);
    send_fields(smf_pkg::OP_START, 32'd5, smf_pkg::SYSEX_START, 29'd1, 16'd10);
    send_fields(smf_pkg::OP_START, 32'd6, smf_pkg::SYSEX_START, 29'h1000_0000, 16'd11);
    send_fields(smf_pkg::OP_START, 32'd7, smf_pkg::SYSEX_START, 29'h1FFF_FFFF, 16'd12);
    // slow tempos clamp, then the slowest unclamped, normal and fastest
    send_fields(smf_pkg::OP_TEMPO, 32'd8, 8'h12, 29'd5, 16'd0);
    send_fields(smf_pkg::OP_TEMPO, 32'd9, 8'h34, 29'd5, 16'd3);
    send_fields(smf_pkg::OP_TEMPO, 32'd10, 8'h56, 29'd5, 16'd4);
    send_fields(smf_pkg::OP_TEMPO, 32'd11, 8'h78, 29'd5, 16'd120);
    send_fields(smf_pkg::OP_TEMPO, 32'd12, 8'h9A, 29'd5, 16'hFFFF);
    send_fields(OP_UNUSED, $urandom, 8'($urandom), 29'($urandom), 16'($urandom));
    cur_tick = 32'd12;

    random_start = events_sent;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      drain_track();
      phase_goal = random_start + RANDOM_EVENTS * (p + 1) / PHASES;
      while (events_sent < phase_goal) begin
        // unused fields carry noise so every input bit toggles
        ev.op = smf_pkg::OP_START;
        ev.song_tick = $urandom;
        ev.data_byte = 8'($urandom);
        ev.msg_length = 29'($urandom);
        ev.tempo_bpm = 16'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
          extra = (status[7:4] == 4'hC || status[7:4] == 4'hD) ? 1 : 2;
          ev.song_tick = next_tick();
          ev.data_byte = status;
          ev.msg_length = 29'(extra + 1);
          send_event(ev);
          repeat (extra) begin
            ev.op = smf_pkg::OP_PAYLOAD;
            ev.song_tick = $urandom;
            ev.data_byte = 8'($urandom_range(0, 127));
            send_event(ev);
          end
        end else if (kind < 50) begin
          extra = $urandom_range(0, 6);
          ev.song_tick = next_tick();
          ev.data_byte = smf_pkg::SYSEX_START;
          if ($urandom_range(0, 9) != 0) ev.msg_length = 29'(extra + 2);
          send_event(ev);
          ev.op = smf_pkg::OP_PAYLOAD;
          repeat (extra) begin
            ev.data_byte = 8'($urandom_range(0, 127));
            send_event(ev);
          end
          ev.data_byte = SYSEX_END;
          send_event(ev);
        end else if (kind < 70) begin
          ev.op = smf_pkg::OP_TEMPO;
          ev.song_tick = next_tick();
          if ($urandom_range(0, 3) != 0) ev.tempo_bpm = 16'($urandom_range(30, 300));
          send_event(ev);
        end else if (kind < 80) begin
          ev.song_tick = next_tick();
          send_event(ev);
        end else if (kind < 90) begin
          ev.op = smf_pkg::OP_PAYLOAD;
          send_event(ev);
        end else if (kind < 95) begin
          ev.op = OP_UNUSED;
          send_event(ev);
        end else begin
          cur_tick = ev.song_tick;
          send_event(ev);
        end
      end
    end

    drain_track();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (trk_sb.pending() != 0)
      trk_sb.report($sformatf("%0d bytes never arrived", trk_sb.pending()));
    if (trk_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/smf_pkg.sv
sv/smf_evt_if.sv
sv/smf_trk_if.sv
sv/smf_div.sv
sv/midi_file_event_serializer.sv
verif/midi_file_event_serializer_test.sv
